// ===== rtl/core/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg
// Types and constants shared by the two-group traffic light sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // The quotient of a 31-bit word by 5000 is (x * GreenRecip) >> GreenShift.
  localparam logic [31:0] GreenRecip   = 32'd3518437209;
  localparam int unsigned GreenShift   = 44;
  localparam logic [12:0] GreenSpan    = 13'd5000;
  localparam logic [13:0] GreenBase    = 14'd5000;
  localparam logic [9:0]  UsPerMs      = 10'd1000;
  localparam logic [25:0] TimerSlackUs = 26'd100000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLINK_MODE        = 3'd0,
    CFG_START_HOLD_MS     = 3'd1,
    CFG_RED_YELLOW_MS     = 3'd2,
    CFG_YELLOW_MS         = 3'd3,
    CFG_RED_MS            = 3'd4,
    CFG_BLINK_HALF_MS     = 3'd5,
    CFG_FIRST_GROUP_ADDR  = 3'd6,
    CFG_SECOND_GROUP_ADDR = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SCN_OFF    = 3'd0,
    SCN_RED    = 3'd1,
    SCN_REDYEL = 3'd2,
    SCN_GREEN  = 3'd3,
    SCN_YELLOW = 3'd4
  } scene_t;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_G1_REDYEL = 4'd1,
    PH_G1_GREEN  = 4'd2,
    PH_G1_YELLOW = 4'd3,
    PH_G1_RED    = 4'd4,
    PH_G2_REDYEL = 4'd5,
    PH_G2_GREEN  = 4'd6,
    PH_G2_YELLOW = 4'd7,
    PH_G2_RED    = 4'd8
  } phase_t;

  typedef enum logic {
    REQ_STEP  = 1'b0,
    REQ_RESET = 1'b1
  } req_t;

  typedef struct packed {
    logic        blink_mode;
    logic [15:0] start_hold_ms;
    logic [15:0] red_yellow_ms;
    logic [15:0] yellow_ms;
    logic [15:0] red_ms;
    logic [15:0] blink_half_ms;
    logic [15:0] first_group_addr;
    logic [15:0] second_group_addr;
  } cfg_t;

  // One scheduled command before its delay arithmetic is done.
  typedef struct packed {
    logic        is_broadcast;
    logic [15:0] target_group;
    scene_t      scene_code;
    logic        use_green;
    logic [15:0] dwell_ms;
    logic [46:0] now_ms;
    logic [30:0] rand_word;
  } cmd_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/tls_step_if.sv =====
// ----------------------------------------------------------------------------
// tls_step_if
// Step request channel: request type, current time and random word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tls_step_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [46:0] now_ms;
  logic [30:0] rand_word;

  modport source (output valid, output req_type, output now_ms, output rand_word,
                  input ready);
  modport sink (input valid, input req_type, input now_ms, input rand_word,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tls_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tls_cmd_if
// Scene command channel toward the light groups.
// ----------------------------------------------------------------------------
`default_nettype none

interface tls_cmd_if;
  logic        valid;
  logic        ready;
  logic        is_broadcast;
  logic [15:0] target_group;
  logic [2:0]  scene_code;
  logic [47:0] due_ms;
  logic [25:0] timer_delay_us;

  modport source (output valid, output is_broadcast, output target_group,
                  output scene_code, output due_ms, output timer_delay_us,
                  input ready);
  modport sink (input valid, input is_broadcast, input target_group,
                input scene_code, input due_ms, input timer_delay_us,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tls_cfg_regs
// Configuration register file with its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_cfg_regs (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [tls_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire [tls_pkg::CfgDataW-1:0]   cfg_wdata,
  output tls_pkg::cfg_t                 cfg
);

  tls_pkg::cfg_idx_t idx;

  assign idx = tls_pkg::cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_mode        <= 1'b0;
      cfg.start_hold_ms     <= 16'd1000;
      cfg.red_yellow_ms     <= 16'd2000;
      cfg.yellow_ms         <= 16'd3000;
      cfg.red_ms            <= 16'd2000;
      cfg.blink_half_ms     <= 16'd1000;
      cfg.first_group_addr  <= 16'd49152;
      cfg.second_group_addr <= 16'd49153;
    end else if (cfg_we) begin
      unique case (idx)
        tls_pkg::CFG_BLINK_MODE:        cfg.blink_mode        <= cfg_wdata[0];
        tls_pkg::CFG_START_HOLD_MS:     cfg.start_hold_ms     <= cfg_wdata;
        tls_pkg::CFG_RED_YELLOW_MS:     cfg.red_yellow_ms     <= cfg_wdata;
        tls_pkg::CFG_YELLOW_MS:         cfg.yellow_ms         <= cfg_wdata;
        tls_pkg::CFG_RED_MS:            cfg.red_ms            <= cfg_wdata;
        tls_pkg::CFG_BLINK_HALF_MS:     cfg.blink_half_ms     <= cfg_wdata;
        tls_pkg::CFG_FIRST_GROUP_ADDR:  cfg.first_group_addr  <= cfg_wdata;
        tls_pkg::CFG_SECOND_GROUP_ADDR: cfg.second_group_addr <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tls_sched.sv =====
// ----------------------------------------------------------------------------
// tls_sched
// Phase state machine; registers the scene decision for each step beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sched (
  input  wire               clk,
  input  wire               rst,
  input  tls_pkg::cfg_t     cfg,
  tls_step_if.sink          step,
  output logic              dec_valid,
  input  wire               dec_ready,
  output tls_pkg::cmd_req_t dec
);

  tls_pkg::phase_t   phase;
  tls_pkg::phase_t   phase_next;
  tls_pkg::phase_t   phase_step;
  tls_pkg::cmd_req_t dec_next;
  logic              acc;
  logic              is_reset_req;

  assign step.ready   = !dec_valid || dec_ready;
  assign acc          = step.valid && step.ready;
  assign is_reset_req = (tls_pkg::req_t'(step.req_type) == tls_pkg::REQ_RESET);

  always_comb begin
    dec_next              = '0;
    dec_next.now_ms       = step.now_ms;
    dec_next.rand_word    = step.rand_word;
    dec_next.is_broadcast = 1'b0;
    dec_next.use_green    = 1'b0;
    phase_step            = tls_pkg::PH_START;
    if (cfg.blink_mode) begin
      dec_next.is_broadcast = 1'b1;
      dec_next.dwell_ms     = cfg.blink_half_ms;
      if (phase == tls_pkg::PH_START) begin
        phase_step          = tls_pkg::PH_G1_REDYEL;
        dec_next.scene_code = tls_pkg::SCN_OFF;
      end else begin
        phase_step          = tls_pkg::PH_START;
        dec_next.scene_code = tls_pkg::SCN_YELLOW;
      end
    end else begin
      unique case (phase)
        tls_pkg::PH_G1_REDYEL: begin
          phase_step            = tls_pkg::PH_G1_GREEN;
          dec_next.target_group = cfg.first_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_REDYEL;
          dec_next.dwell_ms     = cfg.red_yellow_ms;
        end
        tls_pkg::PH_G1_GREEN: begin
          phase_step            = tls_pkg::PH_G1_YELLOW;
          dec_next.target_group = cfg.first_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_GREEN;
          dec_next.use_green    = 1'b1;
        end
        tls_pkg::PH_G1_YELLOW: begin
          phase_step            = tls_pkg::PH_G1_RED;
          dec_next.target_group = cfg.first_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_YELLOW;
          dec_next.dwell_ms     = cfg.yellow_ms;
        end
        tls_pkg::PH_G1_RED: begin
          phase_step            = tls_pkg::PH_G2_REDYEL;
          dec_next.target_group = cfg.first_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_RED;
          dec_next.dwell_ms     = cfg.red_ms;
        end
        tls_pkg::PH_G2_REDYEL: begin
          phase_step            = tls_pkg::PH_G2_GREEN;
          dec_next.target_group = cfg.second_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_REDYEL;
          dec_next.dwell_ms     = cfg.red_yellow_ms;
        end
        tls_pkg::PH_G2_GREEN: begin
          phase_step            = tls_pkg::PH_G2_YELLOW;
          dec_next.target_group = cfg.second_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_GREEN;
          dec_next.use_green    = 1'b1;
        end
        tls_pkg::PH_G2_YELLOW: begin
          phase_step            = tls_pkg::PH_G2_RED;
          dec_next.target_group = cfg.second_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_YELLOW;
          dec_next.dwell_ms     = cfg.yellow_ms;
        end
        tls_pkg::PH_G2_RED: begin
          phase_step            = tls_pkg::PH_G1_REDYEL;
          dec_next.target_group = cfg.second_group_addr;
          dec_next.scene_code   = tls_pkg::SCN_RED;
          dec_next.dwell_ms     = cfg.red_ms;
        end
        default: begin
          phase_step            = tls_pkg::PH_G1_REDYEL;
          dec_next.is_broadcast = 1'b1;
          dec_next.scene_code   = tls_pkg::SCN_RED;
          dec_next.dwell_ms     = cfg.start_hold_ms;
        end
      endcase
    end

    phase_next = phase;
    if (acc) begin
      phase_next = is_reset_req ? tls_pkg::PH_START : phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tls_pkg::PH_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (step.ready) begin
      dec_valid <= acc && !is_reset_req;
    end
  end

  always_ff @(posedge clk) begin
    if (step.ready) begin
      dec <= dec_next;
    end
  end

  a_reset_req_clears_phase: assert property (@(posedge clk) disable iff (rst)
    acc && is_reset_req |=> phase == tls_pkg::PH_START)
    else $error("phase not cleared by a reset-phase beat");

  a_blink_toggles: assert property (@(posedge clk) disable iff (rst)
    acc && !is_reset_req && cfg.blink_mode && phase == tls_pkg::PH_START
      |=> phase == tls_pkg::PH_G1_REDYEL)
    else $error("blink mode did not leave the start phase");

  a_reset_req_no_beat: assert property (@(posedge clk) disable iff (rst)
    acc && is_reset_req |=> !dec_valid)
    else $error("reset-phase beat produced a command");

endmodule

`default_nettype wire

// ===== rtl/core/tls_cmd_pipe.sv =====
// ----------------------------------------------------------------------------
// tls_cmd_pipe
// Green duration, execute time and timer delay, in three elastic stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_cmd_pipe (
  input  wire               clk,
  input  wire               rst,
  input  wire               dec_valid,
  output logic              dec_ready,
  input  tls_pkg::cmd_req_t dec,
  tls_cmd_if.source         cmd
);

  localparam int unsigned QW = 63 - tls_pkg::GreenShift;

  logic              vb;
  logic              vc;
  logic              b_ready;
  logic              c_ready;
  logic              out_ready;
  tls_pkg::cmd_req_t b_req;
  logic [QW-1:0]     b_quot;
  tls_pkg::cmd_req_t c_req;
  logic [15:0]       c_delay;
  logic [62:0]       prod;
  logic [31:0]       quot_x;
  logic [30:0]       rem_full;
  logic [12:0]       rem;
  logic [13:0]       green;

  assign out_ready = !cmd.valid || cmd.ready;
  assign c_ready   = !vc || out_ready;
  assign b_ready   = !vb || c_ready;
  assign dec_ready = b_ready;

  assign prod     = 63'(dec.rand_word) * 63'(tls_pkg::GreenRecip);
  assign quot_x   = 32'(b_quot) * 32'(tls_pkg::GreenSpan);
  assign rem_full = b_req.rand_word - quot_x[30:0];
  assign rem      = rem_full[12:0];
  assign green    = 14'(rem) + tls_pkg::GreenBase;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb        <= 1'b0;
      vc        <= 1'b0;
      cmd.valid <= 1'b0;
    end else begin
      if (b_ready) begin
        vb <= dec_valid;
      end
      if (c_ready) begin
        vc <= vb;
      end
      if (out_ready) begin
        cmd.valid <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_req  <= dec;
      b_quot <= prod[62:tls_pkg::GreenShift];
    end
    if (c_ready) begin
      c_req   <= b_req;
      c_delay <= b_req.use_green ? 16'(green) : b_req.dwell_ms;
    end
    if (out_ready) begin
      cmd.is_broadcast   <= c_req.is_broadcast;
      cmd.target_group   <= c_req.target_group;
      cmd.scene_code     <= c_req.scene_code;
      cmd.due_ms         <= 48'(c_req.now_ms) + 48'(c_delay);
      cmd.timer_delay_us <= 26'(c_delay) * 26'(tls_pkg::UsPerMs) + tls_pkg::TimerSlackUs;
    end
  end

  a_remainder_in_span: assert property (@(posedge clk) disable iff (rst)
    vb |-> rem_full < 31'(tls_pkg::GreenSpan))
    else $error("green remainder out of span");

  a_broadcast_no_group: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.is_broadcast |-> cmd.target_group == 16'd0)
    else $error("broadcast command carries a group address");

  a_timer_has_slack: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> cmd.timer_delay_us >= tls_pkg::TimerSlackUs)
    else $error("timer delay below slack");

endmodule

`default_nettype wire

// ===== rtl/core/two_group_traffic_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// two_group_traffic_light_sequencer
// Steps the light phase and emits one timed scene command per step beat.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  step     in   req_type, now_ms, rand_word
//  cmd      out  is_broadcast, target_group, scene_code, due_ms,
//                timer_delay_us
//  cfg      in   cfg_we, cfg_index, cfg_wdata (write only)
//
//  One step beat is taken every cycle while the cmd channel does not stall; its
//  command passes through the decision, quotient, delay and output registers.
//  A reset-phase beat clears the phase and produces no command.
//  Reset returns the phase to zero, clears the valid flags and loads the config defaults.
//  A stalled cmd channel fills all four registers before step.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_group_traffic_light_sequencer (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire [tls_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire [tls_pkg::CfgDataW-1:0] cfg_wdata,
  tls_step_if.sink                    step,
  tls_cmd_if.source                   cmd
);

  tls_pkg::cfg_t     cfg;
  tls_pkg::cmd_req_t dec;
  logic              dec_valid;
  logic              dec_ready;

  tls_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tls_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  tls_cmd_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .cmd       (cmd)
  );

endmodule

`default_nettype wire

// ===== tb/tb_two_group_traffic_light_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_group_traffic_light_sequencer
// Drives step beats through the traffic light sequencer and checks every
// scene command against a phase predictor kept in the testbench. A short
// stimulus table covers the field extremes, every phase of the normal cycle
// and the reset-phase request. Random phases then follow, each with its own
// register setting, normal and blinking operation, and random idling on both
// channels, including one long stall of the command channel.
// ----------------------------------------------------------------------------

module tb_two_group_traffic_light_sequencer;
  import tls_pkg::*;

  typedef struct packed {
    logic        is_broadcast;
    logic [15:0] target_group;
    scene_t      scene_code;
    logic [47:0] due_ms;
    logic [25:0] timer_delay_us;
  } scene_cmd_t;

  typedef struct {
    req_t        req;
    logic [46:0] now;
    logic [30:0] rnd;
    bit          typed;
    scene_cmd_t  want;
  } step_row_t;

  localparam logic [46:0] MaxNow = 47'h7FFF_FFFF_FFFF;
  localparam logic [30:0] MaxRnd = 31'h7FFF_FFFF;
  localparam scene_cmd_t NoScene = '0;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned ItemsPerPhase = 45;
  localparam int unsigned HoldCycles = 60;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  logic [15:0] cfg_wdata;

  tls_step_if step_ch ();
  tls_cmd_if  cmd_ch ();

  two_group_traffic_light_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step_ch),
    .cmd       (cmd_ch)
  );

  always #5 clk = ~clk;

  cfg_t        cfg_q;
  phase_t      phase_q;
  scene_cmd_t  pending_scenes[$];
  step_row_t   directed_rows[$];
  int          errors = 0;
  logic        tx_calm;
  logic        rx_calm;
  logic        flood_on;

  function automatic bit next_scene(input req_t req, input logic [46:0] now,
                                    input logic [30:0] rnd, output scene_cmd_t c);
    int unsigned green;
    int unsigned timer;
    logic [15:0] delay;
    logic [15:0] grp;
    logic        bcast;
    scene_t      scn;
    phase_t      nxt;
    c = '0;
    if (req == REQ_RESET) begin
      phase_q = PH_START;
      return 1'b0;
    end
    green = (rnd % 5000) + 5000;
    bcast = 1'b0;
    if (cfg_q.blink_mode) begin
      bcast = 1'b1;
      grp   = '0;
      delay = cfg_q.blink_half_ms;
      scn   = (phase_q == PH_START) ? SCN_OFF : SCN_YELLOW;
      nxt   = (phase_q == PH_START) ? PH_G1_REDYEL : PH_START;
    end else begin
      case (phase_q)
        PH_G1_REDYEL: begin
          grp = cfg_q.first_group_addr;  scn = SCN_REDYEL;
          delay = cfg_q.red_yellow_ms;   nxt = PH_G1_GREEN;
        end
        PH_G1_GREEN: begin
          grp = cfg_q.first_group_addr;  scn = SCN_GREEN;
          delay = green[15:0];           nxt = PH_G1_YELLOW;
        end
        PH_G1_YELLOW: begin
          grp = cfg_q.first_group_addr;  scn = SCN_YELLOW;
          delay = cfg_q.yellow_ms;       nxt = PH_G1_RED;
        end
        PH_G1_RED: begin
          grp = cfg_q.first_group_addr;  scn = SCN_RED;
          delay = cfg_q.red_ms;          nxt = PH_G2_REDYEL;
        end
        PH_G2_REDYEL: begin
          grp = cfg_q.second_group_addr; scn = SCN_REDYEL;
          delay = cfg_q.red_yellow_ms;   nxt = PH_G2_GREEN;
        end
        PH_G2_GREEN: begin
          grp = cfg_q.second_group_addr; scn = SCN_GREEN;
          delay = green[15:0];           nxt = PH_G2_YELLOW;
        end
        PH_G2_YELLOW: begin
          grp = cfg_q.second_group_addr; scn = SCN_YELLOW;
          delay = cfg_q.yellow_ms;       nxt = PH_G2_RED;
        end
        PH_G2_RED: begin
          grp = cfg_q.second_group_addr; scn = SCN_RED;
          delay = cfg_q.red_ms;          nxt = PH_G1_REDYEL;
        end
        default: begin
          bcast = 1'b1; grp = '0; scn = SCN_RED;
          delay = cfg_q.start_hold_ms;   nxt = PH_G1_REDYEL;
        end
      endcase
    end
    phase_q = nxt;
    timer = delay * 1000 + 100000;
    c.is_broadcast   = bcast;
    c.target_group   = bcast ? 16'd0 : grp;
    c.scene_code     = scn;
    c.due_ms         = {1'b0, now} + {32'd0, delay};
    c.timer_delay_us = timer[25:0];
    return 1'b1;
  endfunction

  function automatic void add_row(input req_t req, input logic [46:0] now,
                                  input logic [30:0] rnd, input bit typed,
                                  input scene_cmd_t want);
    step_row_t row;
    row.req = req; row.now = now; row.rnd = rnd; row.typed = typed; row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic send_step(input req_t req, input logic [46:0] now,
                           input logic [30:0] rnd, input bit typed,
                           input scene_cmd_t want);
    scene_cmd_t predicted;
    step_ch.valid     <= 1'b1;
    step_ch.req_type  <= req;
    step_ch.now_ms    <= now;
    step_ch.rand_word <= rnd;
    do @(posedge clk); while (!step_ch.ready);
    if (next_scene(req, now, rnd, predicted)) begin
      pending_scenes.push_back(typed ? want : predicted);
    end
    if (!tx_calm && $urandom_range(99) < 4) begin
      step_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BLINK_MODE:        cfg_q.blink_mode        = val[0];
      CFG_START_HOLD_MS:     cfg_q.start_hold_ms     = val;
      CFG_RED_YELLOW_MS:     cfg_q.red_yellow_ms     = val;
      CFG_YELLOW_MS:         cfg_q.yellow_ms         = val;
      CFG_RED_MS:            cfg_q.red_ms            = val;
      CFG_BLINK_HALF_MS:     cfg_q.blink_half_ms     = val;
      CFG_FIRST_GROUP_ADDR:  cfg_q.first_group_addr  = val;
      CFG_SECOND_GROUP_ADDR: cfg_q.second_group_addr = val;
      default: ;
    endcase
  endtask

  // Waits for every outstanding command, then keeps the step channel idle.
  task automatic settle();
    step_ch.valid <= 1'b0;
    while (pending_scenes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    scene_cmd_t want;
    forever begin
      @(posedge clk);
      if (!rst && cmd_ch.valid && cmd_ch.ready) begin
        if (pending_scenes.size() == 0) begin
          $error("scene command with no step beat waiting for it");
          errors++;
        end else begin
          want = pending_scenes.pop_front();
          check_field("is_broadcast", 48'(want.is_broadcast), 48'(cmd_ch.is_broadcast));
          check_field("target_group", 48'(want.target_group), 48'(cmd_ch.target_group));
          check_field("scene_code", 48'(want.scene_code), 48'(cmd_ch.scene_code));
          check_field("due_ms", want.due_ms, cmd_ch.due_ms);
          check_field("timer_delay_us", 48'(want.timer_delay_us),
                      48'(cmd_ch.timer_delay_us));
        end
      end
    end
  end

  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    cmd_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && flood_on) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmd_ch.ready <= 1'b0;
      end else begin
        cmd_ch.ready <= rx_calm || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [63:0] wide;
    logic [46:0] now;
    logic [30:0] rnd;
    logic [15:0] val;
    req_t        req;
    scene_cmd_t  unused;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_BLINK_MODE;
    cfg_wdata         <= '0;
    step_ch.valid     <= 1'b0;
    step_ch.req_type  <= REQ_STEP;
    step_ch.now_ms    <= '0;
    step_ch.rand_word <= '0;
    tx_calm           <= 1'b0;
    rx_calm           <= 1'b0;
    flood_on          <= 1'b0;
    cfg_q   = '{1'b0, 16'd1000, 16'd2000, 16'd3000, 16'd2000, 16'd1000,
                16'd49152, 16'd49153};
    phase_q = PH_START;

    add_row(REQ_STEP, '0, '0, 1'b1,
            '{1'b1, 16'd0, SCN_RED, 48'd1000, 26'd1100000});
    add_row(REQ_STEP, MaxNow, MaxRnd, 1'b1,
            '{1'b0, 16'd49152, SCN_REDYEL, 48'h8000_0000_07CF, 26'd2100000});
    add_row(REQ_STEP, MaxNow, MaxRnd, 1'b1,
            '{1'b0, 16'd49152, SCN_GREEN, 48'h8000_0000_21C6, 26'd8747000});
    add_row(REQ_STEP, '0, '0, 1'b1,
            '{1'b0, 16'd49152, SCN_YELLOW, 48'd3000, 26'd3100000});
    add_row(REQ_STEP, 47'd5, '0, 1'b0, NoScene);
    add_row(REQ_STEP, 47'd77, 31'd12345, 1'b0, NoScene);
    add_row(REQ_STEP, '0, 31'd4999, 1'b1,
            '{1'b0, 16'd49153, SCN_GREEN, 48'd9999, 26'd10099000});
    add_row(REQ_STEP, 47'd123456, '0, 1'b0, NoScene);
    add_row(REQ_STEP, 47'd1, '0, 1'b0, NoScene);
    add_row(REQ_STEP, 47'd2, '0, 1'b0, NoScene);
    add_row(REQ_RESET, MaxNow, MaxRnd, 1'b0, NoScene);
    add_row(REQ_STEP, 47'd1, '0, 1'b0, NoScene);
    add_row(REQ_RESET, '0, '0, 1'b0, NoScene);
    add_row(REQ_RESET, 47'd9, 31'd9, 1'b0, NoScene);
    add_row(REQ_STEP, '0, 31'd5000, 1'b0, NoScene);
    add_row(REQ_STEP, '0, 31'd5000, 1'b0, NoScene);
    add_row(REQ_STEP, '0, 31'd5000, 1'b1,
            '{1'b0, 16'd49152, SCN_GREEN, 48'd5000, 26'd5100000});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_step(directed_rows[i].req, directed_rows[i].now, directed_rows[i].rnd,
                directed_rows[i].typed, directed_rows[i].want);
    end

    for (int k = 0; k < PhaseCount; k++) begin
      settle();
      tx_calm  <= (k == 3) || (k == 4);
      rx_calm  <= (k == 4);
      flood_on <= (k == 3);
      for (int r = 0; r < 8; r++) begin
        if (k == 0) val = 16'h0000;
        else if (k == 1) val = 16'hFFFF;
        else val = 16'($urandom_range(0, 65535));
        if (cfg_idx_t'(r) == CFG_BLINK_MODE) val[0] = (k % 3 == 2);
        write_reg(cfg_idx_t'(r), val);
      end
      cfg_we <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        req = ($urandom_range(99) < 6) ? REQ_RESET : REQ_STEP;
        wide = {$urandom, $urandom};
        case ($urandom_range(9))
          0: now = '0;
          1: now = MaxNow;
          default: now = wide[46:0];
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(9))
          0: rnd = '0;
          1: rnd = MaxRnd;
          default: rnd = wide[30:0];
        endcase
        send_step(req, now, rnd, 1'b0, NoScene);
      end
    end

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
